### hdl/sfd_pkg.sv
package sfd_pkg;

  // Ring store geometry
  localparam int DEPTH    = 131072;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int FRAC_W   = 8;
  localparam int POS_W    = ADDR_W + FRAC_W;
  localparam int SPAN     = DEPTH * 256;

  // Sample and coefficient widths
  localparam int SAMPLE_W = 24;
  localparam int FILT_W   = SAMPLE_W + 8;
  localparam int DELAY_W  = 25;
  localparam int GAIN_W   = 16;
  localparam int COEF_W   = 17;
  localparam int FB_SHIFT = 24;

  // Clamp limits
  localparam int DELAY_MIN = 256;
  localparam int DELAY_MAX = (DEPTH - 2) * 256;
  localparam int GAIN_MAX  = 64225;
  localparam int UNITY     = 65536;

  // Configuration port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [IDX_W-1:0] REG_DELAY  = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN   = 3'd2;
  localparam logic [IDX_W-1:0] REG_TONE   = 3'd3;
  localparam logic [IDX_W-1:0] REG_CROSS  = 3'd4;
  localparam logic [IDX_W-1:0] REG_MIX    = 3'd5;

  localparam logic [DELAY_W-1:0] RST_DELAY = 25'd6144000;
  localparam logic [GAIN_W-1:0]  RST_GAIN  = 16'd0;
  localparam logic [COEF_W-1:0]  RST_TONE  = 17'd65536;
  localparam logic [COEF_W-1:0]  RST_MIX   = 17'd19661;

  typedef struct packed {
    logic                enable;
    logic [DELAY_W-1:0]  delay_samples;
    logic [GAIN_W-1:0]   feedback_gain;
    logic [COEF_W-1:0]   tone_coeff;
    logic                cross_feed;
    logic [COEF_W-1:0]   mix_level;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_INTERP,
    ST_SUM,
    ST_FILT,
    ST_FUPD,
    ST_FBK,
    ST_WRITE,
    ST_PASS
  } state_t;

  typedef struct packed {
    logic capture;
    logic dry_mul;
    logic rd_hi;
    logic take_s0;
    logic interp;
    logic sum;
    logic filt_mul;
    logic filt_upd;
    logic fb_mul;
    logic commit;
    logic pass;
  } cmd_t;

  typedef struct packed {
    logic enable;
    logic out_free;
  } stat_t;

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [63:0] v);
    logic signed [63:0] smax;
    logic signed [63:0] smin;
    smax = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
    smin = -smax - 64'sd1;
    if (v > smax) begin
      return SAMPLE_W'(smax);
    end else if (v < smin) begin
      return SAMPLE_W'(smin);
    end
    return SAMPLE_W'(v);
  endfunction

endpackage

### hdl/sfd_in_if.sv
interface sfd_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sfd_pkg::SAMPLE_W-1:0]   in_left;
  logic signed [sfd_pkg::SAMPLE_W-1:0]   in_right;

  modport source (output valid, output in_left, output in_right, input ready);
  modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

### hdl/sfd_out_if.sv
interface sfd_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sfd_pkg::SAMPLE_W-1:0]   out_left;
  logic signed [sfd_pkg::SAMPLE_W-1:0]   out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

### hdl/sfd_ram.sv
module sfd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 131072,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/sfd_regs.sv
module sfd_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfd_pkg::APB_AW-1:0]    paddr,
  input  logic [sfd_pkg::APB_DW-1:0]    pwdata,
  output logic [sfd_pkg::APB_DW-1:0]    prdata,
  output sfd_pkg::cfg_t                 cfg
);

  logic [sfd_pkg::IDX_W-1:0] idx;
  logic                      wr;

  assign idx = paddr[sfd_pkg::APB_AW-1:2];
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable        <= 1'b1;
      cfg.delay_samples <= sfd_pkg::RST_DELAY;
      cfg.feedback_gain <= sfd_pkg::RST_GAIN;
      cfg.tone_coeff    <= sfd_pkg::RST_TONE;
      cfg.cross_feed    <= 1'b0;
      cfg.mix_level     <= sfd_pkg::RST_MIX;
    end else if (wr) begin
      case (idx)
        sfd_pkg::REG_ENABLE: cfg.enable        <= pwdata[0];
        sfd_pkg::REG_DELAY:  cfg.delay_samples <= pwdata[sfd_pkg::DELAY_W-1:0];
        sfd_pkg::REG_GAIN:   cfg.feedback_gain <= pwdata[sfd_pkg::GAIN_W-1:0];
        sfd_pkg::REG_TONE:   cfg.tone_coeff    <= pwdata[sfd_pkg::COEF_W-1:0];
        sfd_pkg::REG_CROSS:  cfg.cross_feed    <= pwdata[0];
        sfd_pkg::REG_MIX:    cfg.mix_level     <= pwdata[sfd_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sfd_pkg::REG_ENABLE: prdata = sfd_pkg::APB_DW'(cfg.enable);
      sfd_pkg::REG_DELAY:  prdata = sfd_pkg::APB_DW'(cfg.delay_samples);
      sfd_pkg::REG_GAIN:   prdata = sfd_pkg::APB_DW'(cfg.feedback_gain);
      sfd_pkg::REG_TONE:   prdata = sfd_pkg::APB_DW'(cfg.tone_coeff);
      sfd_pkg::REG_CROSS:  prdata = sfd_pkg::APB_DW'(cfg.cross_feed);
      sfd_pkg::REG_MIX:    prdata = sfd_pkg::APB_DW'(cfg.mix_level);
      default:             prdata = '0;
    endcase
  end

endmodule

### hdl/sfd_ctrl.sv
module sfd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sfd_pkg::stat_t stat,
  output sfd_pkg::cmd_t  cmd
);

  sfd_pkg::state_t state;
  sfd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      sfd_pkg::ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.capture = 1'b1;
          state_next  = stat.enable ? sfd_pkg::ST_RD0 : sfd_pkg::ST_PASS;
        end
      end
      sfd_pkg::ST_RD0: begin
        cmd.dry_mul = 1'b1;
        state_next  = sfd_pkg::ST_RD1;
      end
      sfd_pkg::ST_RD1: begin
        cmd.rd_hi   = 1'b1;
        cmd.take_s0 = 1'b1;
        state_next  = sfd_pkg::ST_INTERP;
      end
      sfd_pkg::ST_INTERP: begin
        cmd.interp = 1'b1;
        state_next = sfd_pkg::ST_SUM;
      end
      sfd_pkg::ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = sfd_pkg::ST_FILT;
      end
      sfd_pkg::ST_FILT: begin
        cmd.filt_mul = 1'b1;
        state_next   = sfd_pkg::ST_FUPD;
      end
      sfd_pkg::ST_FUPD: begin
        cmd.filt_upd = 1'b1;
        state_next   = sfd_pkg::ST_FBK;
      end
      sfd_pkg::ST_FBK: begin
        cmd.fb_mul = 1'b1;
        state_next = sfd_pkg::ST_WRITE;
      end
      sfd_pkg::ST_WRITE: begin
        // hold until the output register can take the word
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = sfd_pkg::ST_IDLE;
        end
      end
      sfd_pkg::ST_PASS: begin
        if (stat.out_free) begin
          cmd.pass   = 1'b1;
          state_next = sfd_pkg::ST_IDLE;
        end
      end
      default: state_next = sfd_pkg::ST_IDLE;
    endcase
  end

endmodule

### hdl/sfd_dp.sv
module sfd_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  sfd_pkg::cfg_t                       cfg,
  input  sfd_pkg::cmd_t                       cmd,
  output sfd_pkg::stat_t                      stat,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0] in_left,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0] in_right,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [sfd_pkg::SAMPLE_W-1:0] out_left,
  output logic signed [sfd_pkg::SAMPLE_W-1:0] out_right
);

  localparam int AW   = sfd_pkg::ADDR_W;
  localparam int SW   = sfd_pkg::SAMPLE_W;
  localparam int FW   = sfd_pkg::FILT_W;
  localparam int PW   = sfd_pkg::POS_W;
  localparam int FRW  = sfd_pkg::FRAC_W;
  localparam int GW   = sfd_pkg::GAIN_W;
  localparam int CFW  = sfd_pkg::COEF_W;
  localparam int DW   = sfd_pkg::DELAY_W;
  localparam int CW   = (PW + 1 > DW + 1) ? PW + 1 : DW + 1;
  localparam int IP_W = SW + FRW + 2;
  localparam int TP_W = FW + CFW + 2;
  localparam int MP_W = SW + CFW + 1;
  localparam int MS_W = MP_W + 1;
  localparam int FP_W = FW + GW + 1;
  localparam int FS_W = FP_W - sfd_pkg::FB_SHIFT;
  localparam int WS_W = FS_W + 1;

  // read position
  logic [CW-1:0]  dly_ext;
  logic [CW-1:0]  dly_c;
  logic [CW-1:0]  wp_pos;
  logic [CW-1:0]  pos;
  logic [AW-1:0]  pos_i0;
  logic [AW-1:0]  pos_i1;

  // clamped coefficients
  logic [CFW-1:0] tone_c;
  logic [GW-1:0]  gain_c;
  logic [CFW-1:0] wet_c;
  logic [CFW-1:0] dry_c;

  // state
  logic [AW-1:0]          wp;
  logic                   full;
  logic signed [FW-1:0]   filt_l;
  logic signed [FW-1:0]   filt_r;

  // item registers
  logic signed [SW-1:0]   xl;
  logic signed [SW-1:0]   xr;
  logic [AW-1:0]          i0;
  logic [AW-1:0]          i1;
  logic [FRW-1:0]         frac;
  logic                   v0;
  logic                   v1;
  logic signed [SW-1:0]   s0l;
  logic signed [SW-1:0]   s0r;
  logic signed [IP_W-1:0] ipl;
  logic signed [IP_W-1:0] ipr;
  logic signed [SW-1:0]   dl;
  logic signed [SW-1:0]   dr;
  logic signed [TP_W-1:0] tpl;
  logic signed [TP_W-1:0] tpr;
  logic signed [MP_W-1:0] wpl;
  logic signed [MP_W-1:0] wpr;
  logic signed [MP_W-1:0] dpl;
  logic signed [MP_W-1:0] dpr;
  logic signed [FP_W-1:0] fbl;
  logic signed [FP_W-1:0] fbr;

  // combinational helpers
  logic [2*SW-1:0]        rdata;
  logic [2*SW-1:0]        wdata;
  logic [AW-1:0]          raddr;
  logic signed [SW-1:0]   s1l;
  logic signed [SW-1:0]   s1r;
  logic signed [SW:0]     dfl;
  logic signed [SW:0]     dfr;
  logic signed [SW+1:0]   dsl;
  logic signed [SW+1:0]   dsr;
  logic signed [FW:0]     fdl;
  logic signed [FW:0]     fdr;
  logic signed [FW-1:0]   sel_l;
  logic signed [FW-1:0]   sel_r;
  logic signed [FS_W-1:0] fsl;
  logic signed [FS_W-1:0] fsr;
  logic signed [WS_W-1:0] wsl;
  logic signed [WS_W-1:0] wsr;
  logic signed [SW-1:0]   wl;
  logic signed [SW-1:0]   wr;
  logic signed [MS_W-1:0] msl;
  logic signed [MS_W-1:0] msr;
  logic signed [SW-1:0]   ol;
  logic signed [SW-1:0]   orr;

  always_comb begin
    dly_ext = CW'(cfg.delay_samples);
    if (dly_ext < CW'(sfd_pkg::DELAY_MIN)) begin
      dly_c = CW'(sfd_pkg::DELAY_MIN);
    end else if (dly_ext > CW'(sfd_pkg::DELAY_MAX)) begin
      dly_c = CW'(sfd_pkg::DELAY_MAX);
    end else begin
      dly_c = dly_ext;
    end
    wp_pos = CW'({wp, {FRW{1'b0}}});
    if (wp_pos >= dly_c) begin
      pos = wp_pos - dly_c;
    end else begin
      pos = wp_pos + CW'(sfd_pkg::SPAN) - dly_c;
    end
    pos_i0 = pos[PW-1:FRW];
    pos_i1 = (pos_i0 == AW'(sfd_pkg::DEPTH - 1)) ? '0 : pos_i0 + AW'(1);
  end

  always_comb begin
    tone_c = (cfg.tone_coeff > CFW'(sfd_pkg::UNITY)) ? CFW'(sfd_pkg::UNITY) : cfg.tone_coeff;
    gain_c = (cfg.feedback_gain > GW'(sfd_pkg::GAIN_MAX)) ? GW'(sfd_pkg::GAIN_MAX)
                                                          : cfg.feedback_gain;
    wet_c  = (cfg.mix_level > CFW'(sfd_pkg::UNITY)) ? CFW'(sfd_pkg::UNITY) : cfg.mix_level;
    dry_c  = CFW'(sfd_pkg::UNITY) - wet_c;
  end

  always_comb begin
    s1l   = v1 ? $signed(rdata[2*SW-1:SW]) : '0;
    s1r   = v1 ? $signed(rdata[SW-1:0]) : '0;
    dfl   = (SW+1)'(s1l) - (SW+1)'(s0l);
    dfr   = (SW+1)'(s1r) - (SW+1)'(s0r);
    dsl   = $signed(ipl[IP_W-1:FRW]) + (SW+2)'(s0l);
    dsr   = $signed(ipr[IP_W-1:FRW]) + (SW+2)'(s0r);
    fdl   = (FW+1)'($signed({dl, 8'h00})) - (FW+1)'(filt_l);
    fdr   = (FW+1)'($signed({dr, 8'h00})) - (FW+1)'(filt_r);
    sel_l = cfg.cross_feed ? filt_r : filt_l;
    sel_r = cfg.cross_feed ? filt_l : filt_r;
    fsl   = fbl[FP_W-1:sfd_pkg::FB_SHIFT];
    fsr   = fbr[FP_W-1:sfd_pkg::FB_SHIFT];
    wsl   = WS_W'(fsl) + WS_W'(xl);
    wsr   = WS_W'(fsr) + WS_W'(xr);
    wl    = sfd_pkg::sat_sample(64'(wsl));
    wr    = sfd_pkg::sat_sample(64'(wsr));
    msl   = MS_W'(dpl) + MS_W'(wpl);
    msr   = MS_W'(dpr) + MS_W'(wpr);
    ol    = sfd_pkg::sat_sample(64'($signed(msl[MS_W-1:16])));
    orr   = sfd_pkg::sat_sample(64'($signed(msr[MS_W-1:16])));
    raddr = cmd.rd_hi ? i1 : i0;
    wdata = {wl, wr};
  end

  sfd_ram #(
    .WIDTH (2 * SW),
    .DEPTH (sfd_pkg::DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (wp),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // item datapath, no reset
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      xl   <= in_left;
      xr   <= in_right;
      i0   <= pos_i0;
      i1   <= pos_i1;
      frac <= pos[FRW-1:0];
      v0   <= full || (pos_i0 < wp);
      v1   <= full || (pos_i1 < wp);
    end
    if (cmd.dry_mul) begin
      dpl <= MP_W'(xl) * MP_W'($signed({1'b0, dry_c}));
      dpr <= MP_W'(xr) * MP_W'($signed({1'b0, dry_c}));
    end
    if (cmd.take_s0) begin
      s0l <= v0 ? $signed(rdata[2*SW-1:SW]) : '0;
      s0r <= v0 ? $signed(rdata[SW-1:0]) : '0;
    end
    if (cmd.interp) begin
      ipl <= IP_W'($signed({1'b0, frac})) * IP_W'(dfl);
      ipr <= IP_W'($signed({1'b0, frac})) * IP_W'(dfr);
    end
    if (cmd.sum) begin
      dl <= dsl[SW-1:0];
      dr <= dsr[SW-1:0];
    end
    if (cmd.filt_mul) begin
      tpl <= TP_W'($signed({1'b0, tone_c})) * TP_W'(fdl);
      tpr <= TP_W'($signed({1'b0, tone_c})) * TP_W'(fdr);
    end
    if (cmd.filt_upd) begin
      wpl <= MP_W'(dl) * MP_W'($signed({1'b0, wet_c}));
      wpr <= MP_W'(dr) * MP_W'($signed({1'b0, wet_c}));
    end
    if (cmd.fb_mul) begin
      fbl <= FP_W'(sel_l) * FP_W'($signed({1'b0, gain_c}));
      fbr <= FP_W'(sel_r) * FP_W'($signed({1'b0, gain_c}));
    end
    if (cmd.commit) begin
      out_left  <= ol;
      out_right <= orr;
    end else if (cmd.pass) begin
      out_left  <= xl;
      out_right <= xr;
    end
  end

  // loop state: pointer, wrap flag, filters
  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= '0;
      full   <= 1'b0;
      filt_l <= '0;
      filt_r <= '0;
    end else begin
      if (cmd.filt_upd) begin
        filt_l <= filt_l + tpl[FW+15:16];
        filt_r <= filt_r + tpr[FW+15:16];
      end
      if (cmd.commit) begin
        if (wp == AW'(sfd_pkg::DEPTH - 1)) begin
          wp   <= '0;
          full <= 1'b1;
        end else begin
          wp <= wp + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit || cmd.pass) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.enable   = cfg.enable;
  assign stat.out_free = !out_valid || out_ready;

endmodule

### hdl/stereo_feedback_delay_line.sv
// Stereo cross-feed feedback delay.
// in_ch takes one stereo word (in_left, in_right, signed Q1.23) on valid and
// ready; out_ch gives one processed word per input word in the same order.
// Configuration is an APB-style write port, register i at byte address 4*i;
// pready is tied high and reads return the stored register value.
// An accepted word goes through RD0, RD1, INTERP, SUM, FILT, FUPD, FBK and
// WRITE to the output register, or through PASS with enable low. No word is
// taken before the last is written: the controller steps one item at a time
// through two reads of the single-read-port ring RAM and the multiply stages.
// Reset clears the write pointer, the wrap flag and both filters and loads
// the register defaults. The ring RAM is not swept: entries not yet written
// since reset read as zero through the wrap flag, so the block accepts a
// word in the first cycle after reset.
// A stalled receiver holds the finished word in the output register; the
// block still takes and processes the next input word, then waits with it
// until the output register drains.
module stereo_feedback_delay_line (
  input  logic                          clk,
  input  logic                          rst,
  sfd_in_if.sink                        in_ch,
  sfd_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfd_pkg::APB_AW-1:0]    paddr,
  input  logic [sfd_pkg::APB_DW-1:0]    pwdata,
  output logic [sfd_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  sfd_pkg::cfg_t  cfg;
  sfd_pkg::cmd_t  cmd;
  sfd_pkg::stat_t stat;

  // the port never inserts wait states
  assign pready = 1'b1;

  // register file: write on access phase, read back any time
  sfd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // sequencer: accept in idle, step reads, multiplies, then write back
  sfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic, ring RAM, loop state and output register
  sfd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .in_left   (in_ch.in_left),
    .in_right  (in_ch.in_right),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_left  (out_ch.out_left),
    .out_right (out_ch.out_right)
  );

endmodule

### dv/stereo_feedback_delay_line_tb.sv
module stereo_feedback_delay_line_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [sfd_pkg::SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } frame_t;

  localparam longint SMP_MAX     = 8388607;
  localparam longint SMP_MIN     = -8388608;
  localparam int     NUM_REGS    = int'(sfd_pkg::REG_MIX) + 1;
  localparam int     IDLE_PCT    = 37;
  localparam int     RAND_WORDS  = 1450;
  localparam int     QUIET_LIMIT = 5000;
  localparam int     TAIL_CYCLES = 20;
  localparam int     STEADY_SET  = 4;

  // Addresses past the last register; writes there must change nothing.
  localparam logic [sfd_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [sfd_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [sfd_pkg::APB_AW-1:0] paddr;
  logic [sfd_pkg::APB_DW-1:0] pwdata;
  logic [sfd_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  sfd_in_if  in_ch();
  sfd_out_if out_ch();

  stereo_feedback_delay_line dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Frames waiting to be driven, and echo outputs predicted but not yet seen.
  frame_t in_frames_q[$];
  frame_t echo_out_q[$];

  // Shadow of the delay line: both rings, write pointer, lowpass states and
  // the register images as the port should read them back.
  bit signed [sfd_pkg::SAMPLE_W-1:0] left_ring  [sfd_pkg::DEPTH];
  bit signed [sfd_pkg::SAMPLE_W-1:0] right_ring [sfd_pkg::DEPTH];
  int unsigned                       wr_ptr;
  longint                            left_lp;
  longint                            right_lp;
  logic [sfd_pkg::APB_DW-1:0]        reg_img [NUM_REGS];

  int     errors;
  int     words_in;
  int     words_out;
  int     bypass_words;
  int     cross_words;
  int     settings;
  int     quiet_cycles;
  bit     steady;
  frame_t next_in;
  frame_t taken;
  frame_t want;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Clip to the signed sample range.
  function automatic sample_t clip(input longint v);
    if (v > SMP_MAX) begin
      return sample_t'(SMP_MAX);
    end else if (v < SMP_MIN) begin
      return sample_t'(SMP_MIN);
    end
    return sample_t'(v);
  endfunction

  // Advance the shadow delay line by one frame and return the output frame; in bypass return the input unchanged.
  function automatic frame_t delay_line_frame(input frame_t x);
    frame_t      y;
    longint      xl, xr, dly, pos, fr, dl, dr, tone, gain, wet, fbl, fbr;
    int unsigned i0, i1;
    xl = x.left;
    xr = x.right;
    if (!reg_img[sfd_pkg::REG_ENABLE][0]) begin
      bypass_words++;
      return x;
    end
    if (reg_img[sfd_pkg::REG_CROSS][0]) cross_words++;

    // Clamp the delay, then find the read point behind the write pointer.
    dly = longint'(reg_img[sfd_pkg::REG_DELAY]);
    if (dly < sfd_pkg::DELAY_MIN) dly = sfd_pkg::DELAY_MIN;
    if (dly > sfd_pkg::DELAY_MAX) dly = sfd_pkg::DELAY_MAX;
    pos = longint'(wr_ptr) * 256 + longint'(sfd_pkg::SPAN) - dly;
    if (pos >= longint'(sfd_pkg::SPAN)) pos -= longint'(sfd_pkg::SPAN);
    i0 = int'(pos >>> sfd_pkg::FRAC_W);
    i1 = (i0 + 1) % sfd_pkg::DEPTH;
    fr = pos & 255;

    // Linear interpolation between neighboring taps, floor rounding.
    dl = left_ring[i0];
    dl += (fr * (left_ring[i1] - dl)) >>> 8;
    dr = right_ring[i0];
    dr += (fr * (right_ring[i1] - dr)) >>> 8;

    tone = (reg_img[sfd_pkg::REG_TONE] > sfd_pkg::UNITY) ? sfd_pkg::UNITY
                                                         : longint'(reg_img[sfd_pkg::REG_TONE]);
    left_lp  += (tone * (dl * 256 - left_lp)) >>> 16;
    right_lp += (tone * (dr * 256 - right_lp)) >>> 16;

    gain = (reg_img[sfd_pkg::REG_GAIN] > sfd_pkg::GAIN_MAX) ? sfd_pkg::GAIN_MAX
                                                            : longint'(reg_img[sfd_pkg::REG_GAIN]);
    if (reg_img[sfd_pkg::REG_CROSS][0]) begin
      fbl = (right_lp * gain) >>> sfd_pkg::FB_SHIFT;
      fbr = (left_lp * gain) >>> sfd_pkg::FB_SHIFT;
    end else begin
      fbl = (left_lp * gain) >>> sfd_pkg::FB_SHIFT;
      fbr = (right_lp * gain) >>> sfd_pkg::FB_SHIFT;
    end
    left_ring[wr_ptr]  = clip(xl + fbl);
    right_ring[wr_ptr] = clip(xr + fbr);
    wr_ptr = (wr_ptr + 1) % sfd_pkg::DEPTH;

    wet = (reg_img[sfd_pkg::REG_MIX] > sfd_pkg::UNITY) ? sfd_pkg::UNITY
                                                       : longint'(reg_img[sfd_pkg::REG_MIX]);
    y.left  = clip((xl * (sfd_pkg::UNITY - wet) + dl * wet) >>> 16);
    y.right = clip((xr * (sfd_pkg::UNITY - wet) + dr * wet) >>> 16);
    return y;
  endfunction

  function automatic logic [sfd_pkg::APB_DW-1:0] field_mask(
      input logic [sfd_pkg::IDX_W-1:0] idx);
    case (idx)
      sfd_pkg::REG_ENABLE: return sfd_pkg::APB_DW'(1);
      sfd_pkg::REG_DELAY:  return sfd_pkg::APB_DW'((1 << sfd_pkg::DELAY_W) - 1);
      sfd_pkg::REG_GAIN:   return sfd_pkg::APB_DW'((1 << sfd_pkg::GAIN_W) - 1);
      sfd_pkg::REG_TONE:   return sfd_pkg::APB_DW'((1 << sfd_pkg::COEF_W) - 1);
      sfd_pkg::REG_CROSS:  return sfd_pkg::APB_DW'(1);
      sfd_pkg::REG_MIX:    return sfd_pkg::APB_DW'((1 << sfd_pkg::COEF_W) - 1);
      default:             return '0;
    endcase
  endfunction

  // Mostly full-scale noise, with rails, zero and quiet passages mixed in.
  function automatic sample_t pick_sample();
    case ($urandom_range(15))
      0:       return sample_t'(SMP_MAX);
      1:       return sample_t'(SMP_MIN);
      2:       return '0;
      3, 4:    return sample_t'(int'($urandom_range(0, 8191)) - 4096);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_cycle(input logic wr, input logic [sfd_pkg::IDX_W-1:0] idx,
                           input logic [sfd_pkg::APB_DW-1:0] wdata,
                           output logic [sfd_pkg::APB_DW-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg(input logic [sfd_pkg::IDX_W-1:0] idx);
    logic [sfd_pkg::APB_DW-1:0] rd;
    apb_cycle(1'b0, idx, '0, rd);
    if (rd !== reg_img[idx]) begin
      errors++;
      $display("%0t: register %0d readback mismatch: expected %0h, got %0h",
               $time, idx, reg_img[idx], rd);
    end
  endtask

  // Write a field with random junk above its width; the shadow keeps only
  // the field bits, and spare addresses keep nothing.
  task automatic write_reg(input logic [sfd_pkg::IDX_W-1:0] idx,
                           input logic [sfd_pkg::APB_DW-1:0] field);
    logic [sfd_pkg::APB_DW-1:0] data;
    logic [sfd_pkg::APB_DW-1:0] rd;
    data = ($urandom & ~field_mask(idx)) | (field & field_mask(idx));
    apb_cycle(1'b1, idx, data, rd);
    if (idx <= sfd_pkg::REG_MIX) begin
      reg_img[idx] = data & field_mask(idx);
      check_reg(idx);
    end
  endtask

  // Hold until every queued frame has been taken and every echo checked.
  task automatic settle();
    while (in_frames_q.size() != 0 || in_ch.valid || echo_out_q.size() != 0) begin
      @(negedge clk);
    end
    settings++;
  endtask

  // Driver: present the next queued frame, idling at random unless steady.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken.left  = in_ch.in_left;
        taken.right = in_ch.in_right;
        echo_out_q.push_back(delay_line_frame(taken));
        words_in++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_frames_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          next_in = in_frames_q.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.in_left  <= next_in.left;
          in_ch.in_right <= next_in.right;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted output word with the oldest prediction,
  // and stall the output at random unless steady.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        words_out++;
        if (echo_out_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected output word %0d/%0d", $time,
                   out_ch.out_left, out_ch.out_right);
        end else begin
          want = echo_out_q.pop_front();
          if (out_ch.out_left !== want.left) begin
            errors++;
            $display("%0t: out_left mismatch: expected %0d, got %0d",
                     $time, want.left, out_ch.out_left);
          end
          if (out_ch.out_right !== want.right) begin
            errors++;
            $display("%0t: out_right mismatch: expected %0d, got %0d",
                     $time, want.right, out_ch.out_right);
          end
        end
      end
      out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: end the run when nothing moves on any port for too long.
  always @(posedge clk) begin
    if (rst || psel || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int rand_words;
    int batch;

    // Drive every input to a known value before the first edge.
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_ch.valid    = 1'b0;
    in_ch.in_left  = '0;
    in_ch.in_right = '0;
    out_ch.ready   = 1'b0;
    steady         = 1'b0;
    rand_words     = 0;

    // Shadow registers start at their reset defaults; rings start at zero.
    reg_img[sfd_pkg::REG_ENABLE] = sfd_pkg::APB_DW'(1);
    reg_img[sfd_pkg::REG_DELAY]  = sfd_pkg::APB_DW'(sfd_pkg::RST_DELAY);
    reg_img[sfd_pkg::REG_GAIN]   = sfd_pkg::APB_DW'(sfd_pkg::RST_GAIN);
    reg_img[sfd_pkg::REG_TONE]   = sfd_pkg::APB_DW'(sfd_pkg::RST_TONE);
    reg_img[sfd_pkg::REG_CROSS]  = '0;
    reg_img[sfd_pkg::REG_MIX]    = sfd_pkg::APB_DW'(sfd_pkg::RST_MIX);
    wr_ptr   = 0;
    left_lp  = 0;
    right_lp = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Read back every register at its reset value.
    for (int i = 0; i < NUM_REGS; i++) check_reg(sfd_pkg::IDX_W'(i));

    // Default settings: the long reset delay reads only cleared taps, so
    // the output is the scaled dry signal. Hit the rails and bit patterns.
    in_frames_q.push_back('{sample_t'(SMP_MAX), sample_t'(SMP_MIN)});
    in_frames_q.push_back('{sample_t'(SMP_MIN), sample_t'(SMP_MAX)});
    in_frames_q.push_back('{sample_t'(0), sample_t'(-1)});
    in_frames_q.push_back('{sample_t'(24'h555555), sample_t'(24'haaaaaa)});
    in_frames_q.push_back('{sample_t'(24'haaaaaa), sample_t'(24'h555555)});
    in_frames_q.push_back('{sample_t'(1), sample_t'(0)});
    settle();

    // Every field out of range: delay below one sample, gain, tone and mix
    // above their limits, crossed feedback. Spare addresses must be ignored.
    // A one-sample loop near full gain drives the rings into saturation.
    write_reg(sfd_pkg::REG_DELAY, '0);
    write_reg(sfd_pkg::REG_GAIN, sfd_pkg::APB_DW'((1 << sfd_pkg::GAIN_W) - 1));
    write_reg(sfd_pkg::REG_TONE, sfd_pkg::APB_DW'((1 << sfd_pkg::COEF_W) - 1));
    write_reg(sfd_pkg::REG_MIX, sfd_pkg::APB_DW'((1 << sfd_pkg::COEF_W) - 1));
    write_reg(sfd_pkg::REG_CROSS, sfd_pkg::APB_DW'(1));
    write_reg(REG_SPARE_LO, sfd_pkg::APB_DW'($urandom));
    write_reg(REG_SPARE_HI, sfd_pkg::APB_DW'($urandom));
    repeat (4) in_frames_q.push_back('{sample_t'(SMP_MAX), sample_t'(SMP_MIN)});
    repeat (4) in_frames_q.push_back('{sample_t'(SMP_MIN), sample_t'(SMP_MAX)});
    settle();

    // Bypass: output equals input and the shadow state holds still.
    write_reg(sfd_pkg::REG_ENABLE, '0);
    in_frames_q.push_back('{sample_t'(SMP_MAX), sample_t'(SMP_MIN)});
    in_frames_q.push_back('{sample_t'(SMP_MIN), sample_t'(SMP_MAX)});
    in_frames_q.push_back('{sample_t'(-1), sample_t'(0)});
    in_frames_q.push_back('{sample_t'(24'h555555), sample_t'(24'haaaaaa)});
    in_frames_q.push_back('{sample_t'(24'haaaaaa), sample_t'(24'h555555)});
    in_frames_q.push_back('{sample_t'(0), sample_t'(1)});
    settle();

    // Delay above its limit, fully wet, frozen filter, no feedback.
    write_reg(sfd_pkg::REG_ENABLE, sfd_pkg::APB_DW'(1));
    write_reg(sfd_pkg::REG_DELAY, sfd_pkg::APB_DW'((1 << sfd_pkg::DELAY_W) - 1));
    write_reg(sfd_pkg::REG_MIX, sfd_pkg::APB_DW'(sfd_pkg::UNITY));
    write_reg(sfd_pkg::REG_TONE, '0);
    write_reg(sfd_pkg::REG_GAIN, '0);
    in_frames_q.push_back('{sample_t'(SMP_MAX), sample_t'(SMP_MAX)});
    in_frames_q.push_back('{sample_t'(SMP_MIN), sample_t'(SMP_MIN)});
    in_frames_q.push_back('{sample_t'(-1), sample_t'(-1)});
    settle();

    // Random settings, one batch of frames each. Short delays dominate so
    // the feedback path sees real history; one batch runs with no idling.
    while (rand_words < RAND_WORDS) begin
      write_reg(sfd_pkg::REG_ENABLE, sfd_pkg::APB_DW'($urandom_range(99) < 85));
      case ($urandom_range(9))
        0: write_reg(sfd_pkg::REG_DELAY,
                     sfd_pkg::APB_DW'($urandom_range(0, sfd_pkg::DELAY_MIN - 1)));
        1: write_reg(sfd_pkg::REG_DELAY, sfd_pkg::APB_DW'(sfd_pkg::DELAY_MIN));
        2: write_reg(sfd_pkg::REG_DELAY, sfd_pkg::APB_DW'(sfd_pkg::DELAY_MAX));
        3: write_reg(sfd_pkg::REG_DELAY,
                     sfd_pkg::APB_DW'($urandom_range(sfd_pkg::DELAY_MAX + 1,
                                                     (1 << sfd_pkg::DELAY_W) - 1)));
        4: write_reg(sfd_pkg::REG_DELAY,
                     sfd_pkg::APB_DW'($urandom_range(sfd_pkg::DELAY_MIN, 1600 * 256)));
        default: write_reg(sfd_pkg::REG_DELAY,
                           sfd_pkg::APB_DW'($urandom_range(sfd_pkg::DELAY_MIN, 48 * 256)));
      endcase
      case ($urandom_range(5))
        0: write_reg(sfd_pkg::REG_GAIN, '0);
        1: write_reg(sfd_pkg::REG_GAIN, sfd_pkg::APB_DW'(sfd_pkg::GAIN_MAX));
        2: write_reg(sfd_pkg::REG_GAIN,
                     sfd_pkg::APB_DW'($urandom_range(sfd_pkg::GAIN_MAX + 1,
                                                     (1 << sfd_pkg::GAIN_W) - 1)));
        default: write_reg(sfd_pkg::REG_GAIN,
                           sfd_pkg::APB_DW'($urandom_range(0, sfd_pkg::GAIN_MAX)));
      endcase
      case ($urandom_range(5))
        0: write_reg(sfd_pkg::REG_TONE, '0);
        1: write_reg(sfd_pkg::REG_TONE, sfd_pkg::APB_DW'(sfd_pkg::UNITY));
        2: write_reg(sfd_pkg::REG_TONE,
                     sfd_pkg::APB_DW'($urandom_range(sfd_pkg::UNITY + 1,
                                                     (1 << sfd_pkg::COEF_W) - 1)));
        default: write_reg(sfd_pkg::REG_TONE,
                           sfd_pkg::APB_DW'($urandom_range(0, sfd_pkg::UNITY)));
      endcase
      case ($urandom_range(5))
        0: write_reg(sfd_pkg::REG_MIX, '0);
        1: write_reg(sfd_pkg::REG_MIX, sfd_pkg::APB_DW'(sfd_pkg::UNITY));
        2: write_reg(sfd_pkg::REG_MIX,
                     sfd_pkg::APB_DW'($urandom_range(sfd_pkg::UNITY + 1,
                                                     (1 << sfd_pkg::COEF_W) - 1)));
        default: write_reg(sfd_pkg::REG_MIX,
                           sfd_pkg::APB_DW'($urandom_range(0, sfd_pkg::UNITY)));
      endcase
      write_reg(sfd_pkg::REG_CROSS, sfd_pkg::APB_DW'($urandom_range(1)));
      if ($urandom_range(3) == 0) write_reg(REG_SPARE_LO, sfd_pkg::APB_DW'($urandom));
      if ($urandom_range(3) == 0) write_reg(REG_SPARE_HI, sfd_pkg::APB_DW'($urandom));

      steady = (settings == STEADY_SET);
      batch  = $urandom_range(80, 160);
      repeat (batch) in_frames_q.push_back('{pick_sample(), pick_sample()});
      rand_words += batch;
      settle();
      steady = 1'b0;
    end

    // Let the pipeline drain; any stray word is caught by the monitor.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d frames in, %0d words out, over %0d register settings",
             words_in, words_out, settings);
    $display("  %0d frames in bypass, %0d with crossed feedback, %0d errors",
             bypass_words, cross_words, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
hdl/sfd_pkg.sv
hdl/sfd_in_if.sv
hdl/sfd_out_if.sv
hdl/sfd_ram.sv
hdl/sfd_regs.sv
hdl/sfd_ctrl.sv
hdl/sfd_dp.sv
hdl/stereo_feedback_delay_line.sv
dv/stereo_feedback_delay_line_tb.sv
